FILE: rtl/telemetry_frame_deframer_core_defines.svh
// assertion macros shared by the telemetry frame deframer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef TELEMETRY_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define TELEMETRY_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfd assertion failed");

// next-cycle implication, disabled while reset is high
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfd assertion failed");

`endif

FILE: rtl/tfd_pkg.sv
// types, constants and the function code classifier for the telemetry deframer
// no dependencies; used by every rtl module of the block
package tfd_pkg;

   localparam logic [7:0] HEADER_BYTE  = 8'h88;
   localparam logic [7:0] RESTART_BYTE = 8'h10;
   localparam int unsigned FRAME_LEN = 11;
   localparam int unsigned PAYLOAD_LEN = 8;
   localparam int unsigned DEFAULT_INDEX_LIMIT = 100;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

   // function code range boundaries
   localparam logic [7:0] CODE_VOLT_LAST   = 8'h63;
   localparam logic [7:0] CODE_TEMP_FIRST  = 8'h64;
   localparam logic [7:0] CODE_TEMP_LAST   = 8'h95;
   localparam logic [7:0] CODE_SINGLE_LO   = 8'h96;
   localparam logic [7:0] CODE_SINGLE_LO_LAST = 8'h9B;
   localparam logic [7:0] CODE_CONFIG_FIRST  = 8'hA0;
   localparam logic [7:0] CODE_CONFIG_LAST   = 8'hA2;
   localparam logic [7:0] CODE_ALARM_FIRST   = 8'hA3;
   localparam logic [7:0] CODE_ALARM_LAST    = 8'hA6;
   localparam logic [7:0] CODE_PROTECT_FIRST = 8'hA7;
   localparam logic [7:0] CODE_PROTECT_LAST  = 8'hAA;
   localparam logic [7:0] CODE_RECOVER_FIRST = 8'hAB;
   localparam logic [7:0] CODE_RECOVER_LAST  = 8'hAE;
   localparam logic [7:0] CODE_SINGLE_HI      = 8'hB8;
   localparam logic [7:0] CODE_SINGLE_HI_LAST = 8'hBA;
   localparam logic [7:0] CODE_BALANCE_FIRST  = 8'hC0;
   localparam logic [7:0] CODE_BALANCE_LAST   = 8'hCF;

   // frame kinds
   localparam logic [3:0] KIND_CELL_VOLT   = 4'd0;
   localparam logic [3:0] KIND_CELL_TEMP   = 4'd1;
   localparam logic [3:0] KIND_VOLT_EXTR   = 4'd2;
   localparam logic [3:0] KIND_PACK_CONFIG = 4'd8;
   localparam logic [3:0] KIND_ALARM       = 4'd9;
   localparam logic [3:0] KIND_PROTECT     = 4'd10;
   localparam logic [3:0] KIND_RECOVER     = 4'd11;
   localparam logic [3:0] KIND_VOLT_CAL    = 4'd12;
   localparam logic [3:0] KIND_BAL_STATE   = 4'd15;

   // one completed frame as it travels from front to back
   typedef struct packed {
      logic [7:0]                  code;
      logic [PAYLOAD_LEN-1:0][7:0] payload;
   } frame_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       known;
      logic [3:0] kind;
      logic [6:0] sub;
   } class_type;

   function automatic class_type classify(input logic [7:0] code);
      class_type c;
      c.known = 1'b1;
      c.kind  = KIND_CELL_VOLT;
      c.sub   = 7'd0;
      priority if (code <= CODE_VOLT_LAST) begin
         c.sub = code[6:0];
      end else if (code <= CODE_TEMP_LAST) begin
         c.kind = KIND_CELL_TEMP;
         c.sub  = 7'(code - CODE_TEMP_FIRST);
      end else if (code <= CODE_SINGLE_LO_LAST) begin
         c.kind = KIND_VOLT_EXTR + 4'(code - CODE_SINGLE_LO);
      end else if (code >= CODE_CONFIG_FIRST && code <= CODE_CONFIG_LAST) begin
         c.kind = KIND_PACK_CONFIG;
         c.sub  = 7'(code - CODE_CONFIG_FIRST);
      end else if (code >= CODE_ALARM_FIRST && code <= CODE_ALARM_LAST) begin
         c.kind = KIND_ALARM;
         c.sub  = 7'(code - CODE_ALARM_FIRST);
      end else if (code >= CODE_PROTECT_FIRST && code <= CODE_PROTECT_LAST) begin
         c.kind = KIND_PROTECT;
         c.sub  = 7'(code - CODE_PROTECT_FIRST);
      end else if (code >= CODE_RECOVER_FIRST && code <= CODE_RECOVER_LAST) begin
         c.kind = KIND_RECOVER;
         c.sub  = 7'(code - CODE_RECOVER_FIRST);
      end else if (code >= CODE_SINGLE_HI && code <= CODE_SINGLE_HI_LAST) begin
         c.kind = KIND_VOLT_CAL + 4'(code - CODE_SINGLE_HI);
      end else if (code >= CODE_BALANCE_FIRST && code <= CODE_BALANCE_LAST) begin
         c.kind = KIND_BAL_STATE;
         c.sub  = 7'(code - CODE_BALANCE_FIRST);
      end else begin
         c.known = 1'b0;
      end
      return c;
   endfunction

endpackage

FILE: rtl/tfd_front.sv
// byte-level front end: header tracking, write index and frame buffer
// depends on tfd_pkg
module tfd_front #(
   parameter int unsigned INDEX_LIMIT = tfd_pkg::DEFAULT_INDEX_LIMIT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [7:0]                req_byte_in,
   input  tfd_pkg::queue_status_type q_status,
   output logic                      req_stall,
   output logic                      push,
   output tfd_pkg::frame_type        push_frame
);

   localparam int unsigned IDX_W = $clog2(INDEX_LIMIT);

   logic                header_pending_ff, header_pending_in;
   logic [IDX_W-1:0]    write_index_ff, write_index_in;
   logic [7:0]          store_ff [tfd_pkg::FRAME_LEN];
   logic                accept, is_header, is_restart, do_store;
   logic [IDX_W:0]      index_sum;
   logic [IDX_W-1:0]    index_adv;

   assign req_stall  = q_status.full;
   assign accept     = req_valid && !req_stall;
   assign is_header  = (req_byte_in == tfd_pkg::HEADER_BYTE);
   assign is_restart = (req_byte_in == tfd_pkg::RESTART_BYTE);
   assign do_store   = !(is_restart && header_pending_ff);

   // advance with saturation just below the limit
   assign index_sum = {1'b0, write_index_ff} + (IDX_W+1)'(1);
   assign index_adv = (index_sum >= (IDX_W+1)'(INDEX_LIMIT)) ?
                      IDX_W'(INDEX_LIMIT - 1) : index_sum[IDX_W-1:0];

   always_comb begin
      header_pending_in = header_pending_ff;
      write_index_in    = write_index_ff;
      if (accept) begin
         header_pending_in = is_header;
         write_index_in    = do_store ? index_adv : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pending_ff <= 1'b0;
         write_index_ff    <= '0;
      end else begin
         header_pending_ff <= header_pending_in;
         write_index_ff    <= write_index_in;
      end
   end

   for (genvar i = 0; i < tfd_pkg::FRAME_LEN; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (accept && do_store && write_index_ff == IDX_W'(i)) begin
            store_ff[i] <= req_byte_in;
         end
      end
   end

   // an ordinary byte landing at the last slot completes the frame
   assign push = accept && !is_header && !is_restart &&
                 (write_index_ff == IDX_W'(tfd_pkg::FRAME_LEN - 1));

   always_comb begin
      push_frame.code = store_ff[1];
      for (int j = 0; j < tfd_pkg::PAYLOAD_LEN - 1; j++) begin
         push_frame.payload[j] = store_ff[3 + j];
      end
      push_frame.payload[tfd_pkg::PAYLOAD_LEN-1] = req_byte_in;
   end

endmodule

FILE: rtl/tfd_queue.sv
// short frame queue between the front end and the classifier
// depends on tfd_pkg
module tfd_queue #(
   parameter int unsigned DEPTH = tfd_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tfd_pkg::frame_type        push_frame,
   input  logic                      pop,
   output tfd_pkg::frame_type        pop_frame,
   output tfd_pkg::queue_status_type q_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tfd_pkg::frame_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_frame      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

FILE: rtl/tfd_back.sv
// back end: classifies queued frames and holds the result register
// depends on tfd_pkg
module tfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tfd_pkg::queue_status_type q_status,
   input  tfd_pkg::frame_type        pop_frame,
   output logic                      pop,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_frame_kind,
   output logic [6:0]                rsp_sub_index,
   output logic [7:0]                rsp_function_code,
   output logic [tfd_pkg::PAYLOAD_LEN-1:0][7:0] rsp_payload
);

   tfd_pkg::class_type cls;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         kind_ff;
   logic [6:0]         sub_ff;
   tfd_pkg::frame_type frame_ff;

   assign cls = tfd_pkg::classify(pop_frame.code);
   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   // unknown codes are popped and dropped
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = cls.known;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= cls.kind;
         sub_ff   <= cls.sub;
         frame_ff <= pop_frame;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_sub_index     = sub_ff;
   assign rsp_function_code = frame_ff.code;
   assign rsp_payload       = frame_ff.payload;

endmodule

FILE: rtl/telemetry_frame_deframer_core.sv
// top level of the telemetry frame deframer
// depends on tfd_pkg, tfd_front, tfd_queue and tfd_back
//
// takes one received byte per transaction and rebuilds 11-byte telemetry
// frames. 0x88 arms a header flag (and is stored), 0x10 right after it
// restarts the frame at position 0, every other byte is stored at the write
// index. an ordinary byte filling position 10 completes the frame; its function
// code (frame byte 1) is sorted into one of sixteen kinds with a sub-index and
// one result transaction carries kind, sub-index, code and frame bytes 3..10.
// frames with an unknown code produce no result. the byte side takes one
// transaction every cycle; a completed frame goes into a short queue
// (QUEUE_DEPTH entries) ahead of the classifier and result register, so the
// byte side stalls only while that queue is full, i.e. when results are held
// back downstream. a completed frame is registered in the queue and then in the result register before rsp_valid rises.
// the write index saturates at INDEX_LIMIT-1. no clearing pass after reset.
module telemetry_frame_deframer_core #(
   parameter int unsigned INDEX_LIMIT = tfd_pkg::DEFAULT_INDEX_LIMIT,
   parameter int unsigned QUEUE_DEPTH = tfd_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // byte channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_frame_kind,
   output logic [6:0] rsp_sub_index,
   output logic [7:0] rsp_function_code,
   output logic [7:0] rsp_payload_0,
   output logic [7:0] rsp_payload_1,
   output logic [7:0] rsp_payload_2,
   output logic [7:0] rsp_payload_3,
   output logic [7:0] rsp_payload_4,
   output logic [7:0] rsp_payload_5,
   output logic [7:0] rsp_payload_6,
   output logic [7:0] rsp_payload_7
);

   tfd_pkg::queue_status_type q_status;
   tfd_pkg::frame_type        push_frame, pop_frame;
   logic                      push, pop;
   logic [tfd_pkg::PAYLOAD_LEN-1:0][7:0] payload;

   // front end: header flag, write index, frame buffer
   tfd_front #(
      .INDEX_LIMIT(INDEX_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_byte_in(req_byte_in),
      .q_status   (q_status),
      .req_stall  (req_stall),
      .push       (push),
      .push_frame (push_frame)
   );

   // completed frames wait here for the classifier
   tfd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_frame(push_frame),
      .pop       (pop),
      .pop_frame (pop_frame),
      .q_status  (q_status)
   );

   // classifier and result register
   tfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_frame        (pop_frame),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_sub_index    (rsp_sub_index),
      .rsp_function_code(rsp_function_code),
      .rsp_payload      (payload)
   );

   // payload bytes out as separate ports, frame bytes 3..10
   assign rsp_payload_0 = payload[0];
   assign rsp_payload_1 = payload[1];
   assign rsp_payload_2 = payload[2];
   assign rsp_payload_3 = payload[3];
   assign rsp_payload_4 = payload[4];
   assign rsp_payload_5 = payload[5];
   assign rsp_payload_6 = payload[6];
   assign rsp_payload_7 = payload[7];

endmodule

FILE: rtl/tfd_checker.sv
// port-level assertions for the telemetry frame deframer, bound to the top level
// depends on tfd_pkg and telemetry_frame_deframer_core_defines.svh
`include "telemetry_frame_deframer_core_defines.svh"

module tfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_frame_kind,
   input logic [6:0] rsp_sub_index,
   input logic [7:0] rsp_function_code,
   input logic [7:0] rsp_payload_0,
   input logic [7:0] rsp_payload_1,
   input logic [7:0] rsp_payload_2,
   input logic [7:0] rsp_payload_3,
   input logic [7:0] rsp_payload_4,
   input logic [7:0] rsp_payload_5,
   input logic [7:0] rsp_payload_6,
   input logic [7:0] rsp_payload_7
);

   logic [82:0] rsp_fields;
   logic        is_volt;
   logic        volt_ok;

   assign rsp_fields = {rsp_frame_kind, rsp_sub_index, rsp_function_code,
                        rsp_payload_7, rsp_payload_6, rsp_payload_5, rsp_payload_4,
                        rsp_payload_3, rsp_payload_2, rsp_payload_1, rsp_payload_0};
   assign is_volt    = rsp_valid && (rsp_frame_kind == tfd_pkg::KIND_CELL_VOLT);
   assign volt_ok    = (rsp_sub_index == rsp_function_code[6:0]) &&
                       (rsp_function_code <= tfd_pkg::CODE_VOLT_LAST);

   // a stalled result stays up
   `TFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result keeps every field
   `TFD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_fields))

   // codes above the balance range never reach the result side
   `TFD_ASSERT_NOW(a_known_code, clock, reset, rsp_valid, rsp_function_code <= tfd_pkg::CODE_BALANCE_LAST)

   // cell voltage frames carry their own code as sub-index
   `TFD_ASSERT_NOW(a_volt_sub, clock, reset, is_volt, volt_ok)

   // the byte side only stalls behind a waiting result
   `TFD_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid)

endmodule

bind telemetry_frame_deframer_core tfd_checker u_tfd_checker (.*);
